// ===== rtl/assert_macros.svh =====
// Assertion macros for the block pool allocator RTL.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, held off while reset is asserted.
`define FBPA_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define FBPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/fbpa_pkg.sv =====
// Shared types and constants for the fixed block pool allocator.
// No dependencies.
package fbpa_pkg;

  localparam int unsigned MaxBlocks = 64;
  localparam int unsigned IdxW      = 6;
  localparam int unsigned CntW      = 7;

  typedef logic [IdxW-1:0] blk_idx_t;
  typedef logic [CntW-1:0] blk_cnt_t;

  typedef enum logic [1:0] {
    OUT_GRANTED   = 2'd0,
    OUT_EXHAUSTED = 2'd1,
    OUT_RELEASED  = 2'd2,
    OUT_IGNORED   = 2'd3
  } outcome_e;

  typedef enum logic {
    KIND_ALLOC   = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_e;

endpackage

// ===== rtl/fixed_block_pool_allocator_core.sv =====
// Top level of the fixed block pool allocator: free-index stack and taken flags.
// Depends on fbpa_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request: kind_i selects
//   allocate or release, block_index_i names the block on release. The result
//   channel (out_valid_o / out_stall_i) returns granted_index_o and outcome_o,
//   one result per request, in request order.
//   A request has two steps: the transfer edge issues reads of the stack and
//   flag memories, and the update step then uses the registered read data to do
//   the read-modify-write and load the output register. One request is in flight
//   at a time: a new request is not taken before the last one has left its update step.
//   The output register holds a finished result while the receiver stalls; a
//   new request is still taken then, and waits in its update step until the
//   output register frees up.
//   Reset (rst_ni low, asynchronous) empties the stack, rewinds the never-used
//   counter, marks every block free through per-entry valid bits and sets the
//   pool size to 64. No clearing pass is needed; requests are taken right away.
//   cfg_we_i / cfg_wdata_i write the pool size; write it only while idle.
`include "assert_macros.svh"

module fixed_block_pool_allocator_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic [5:0] block_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [5:0] granted_index_o,
  output logic [1:0] outcome_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRmw  = 1'b1;

  localparam fbpa_pkg::blk_cnt_t PoolMax   = fbpa_pkg::CntW'(fbpa_pkg::MaxBlocks);
  localparam fbpa_pkg::blk_cnt_t PoolReset = 7'd64;

  logic                 state_q, state_d;
  fbpa_pkg::blk_cnt_t   pool_size_q;
  fbpa_pkg::blk_cnt_t   next_unused_q, next_unused_d;
  fbpa_pkg::blk_cnt_t   depth_q, depth_d;
  logic                 kind_q;
  fbpa_pkg::blk_idx_t   idx_q;

  // memories, registered read
  fbpa_pkg::blk_idx_t   stack_mem [fbpa_pkg::MaxBlocks];
  logic                 flag_mem  [fbpa_pkg::MaxBlocks];
  fbpa_pkg::blk_idx_t   stk_rdata_q;
  logic                 flag_rdata_q;
  logic                 flag_vld_rdata_q;
  logic [fbpa_pkg::MaxBlocks-1:0] flag_vld_q;

  logic                 accept;
  logic                 finish;
  fbpa_pkg::blk_idx_t   stk_raddr;
  logic                 stk_we;
  logic                 flag_we;
  fbpa_pkg::blk_idx_t   flag_waddr;
  logic                 flag_wdata;
  fbpa_pkg::blk_cnt_t   pool_bound;
  logic                 is_taken;

  logic                 out_valid_q;
  fbpa_pkg::blk_idx_t   granted_q, granted_d;
  fbpa_pkg::outcome_e   outcome_q, outcome_d;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && (state_q == StIdle);
  assign finish     = (state_q == StRmw) && (!out_valid_q || !out_stall_i);
  assign stk_raddr  = fbpa_pkg::IdxW'(depth_q - 7'd1);
  assign pool_bound = (pool_size_q > PoolMax) ? PoolMax : pool_size_q;
  assign is_taken   = flag_vld_rdata_q && flag_rdata_q;

  // read-modify-write step
  always_comb begin
    state_d       = state_q;
    next_unused_d = next_unused_q;
    depth_d       = depth_q;
    stk_we        = 1'b0;
    flag_we       = 1'b0;
    flag_waddr    = idx_q;
    flag_wdata    = 1'b0;
    granted_d     = '0;
    outcome_d     = fbpa_pkg::OUT_IGNORED;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StRmw;
        end
      end
      StRmw: begin
        if (kind_q == fbpa_pkg::KIND_ALLOC) begin
          if (depth_q != '0) begin
            granted_d = stk_rdata_q;
            outcome_d = fbpa_pkg::OUT_GRANTED;
            depth_d   = depth_q - 7'd1;
          end else if (next_unused_q < pool_bound) begin
            granted_d     = fbpa_pkg::IdxW'(next_unused_q);
            outcome_d     = fbpa_pkg::OUT_GRANTED;
            next_unused_d = next_unused_q + 7'd1;
          end else begin
            outcome_d = fbpa_pkg::OUT_EXHAUSTED;
          end
          flag_waddr = granted_d;
          flag_wdata = 1'b1;
          flag_we    = (outcome_d == fbpa_pkg::OUT_GRANTED);
        end else begin
          if (is_taken && (depth_q < PoolMax)) begin
            outcome_d = fbpa_pkg::OUT_RELEASED;
            depth_d   = depth_q + 7'd1;
            stk_we    = 1'b1;
            flag_we   = 1'b1;
          end
        end
        if (finish) begin
          state_d = StIdle;
        end else begin
          // hold until the output register frees up
          next_unused_d = next_unused_q;
          depth_d       = depth_q;
          stk_we        = 1'b0;
          flag_we       = 1'b0;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      pool_size_q   <= PoolReset;
      next_unused_q <= '0;
      depth_q       <= '0;
      flag_vld_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      next_unused_q <= next_unused_d;
      depth_q       <= depth_d;
      if (cfg_we_i) begin
        pool_size_q <= cfg_wdata_i;
      end
      if (flag_we) begin
        flag_vld_q[flag_waddr] <= 1'b1;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      idx_q  <= block_index_i;
    end
    if (finish) begin
      granted_q <= granted_d;
      outcome_q <= outcome_d;
    end
  end

  // free-index stack memory
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[fbpa_pkg::IdxW'(depth_q)] <= idx_q;
    end
    if (accept) begin
      stk_rdata_q <= stack_mem[stk_raddr];
    end
  end

  // taken-flag memory
  always_ff @(posedge clk_i) begin
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
    if (accept) begin
      flag_rdata_q     <= flag_mem[block_index_i];
      flag_vld_rdata_q <= flag_vld_q[block_index_i];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_index_o = granted_q;
  assign outcome_o       = outcome_q;

  `FBPA_ASSERT_RST(a_depth_bound, clk_i, rst_ni, depth_q <= PoolMax, "stack depth beyond pool")
  `FBPA_ASSERT_RST(a_unused_bound, clk_i, rst_ni, next_unused_q <= PoolMax, "never-used index beyond pool")
  `FBPA_ASSERT_RST(a_grant_zero, clk_i, rst_ni, (out_valid_q && (outcome_q != fbpa_pkg::OUT_GRANTED)) |-> (granted_q == '0), "nonzero index without grant")
  `FBPA_ASSERT_RST(a_depth_step, clk_i, rst_ni, (depth_q != $past(depth_q)) |-> ($past(finish) && out_valid_q), "stack depth moved outside completion")

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for fixed_block_pool_allocator_core: allocate and release traffic
// checked against an in-bench model of the free-index stack and the taken flags.
// Depends on fbpa_pkg and the RTL under rtl/.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomTarget = 1150;
  localparam int unsigned PhaseItems   = 120;

  typedef struct packed {
    fbpa_pkg::blk_idx_t grant;
    fbpa_pkg::outcome_e outc;
  } alloc_result_t;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       cfg_we      = 1'b0;
  logic [6:0] cfg_wdata   = '0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic       kind        = fbpa_pkg::KIND_ALLOC;
  logic [5:0] blk_idx     = '0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [5:0] grant_idx;
  logic [1:0] outcome;

  alloc_result_t pending_results[$];
  int unsigned   error_count  = 0;
  int unsigned   item_count   = 0;
  bit            quiet_phase  = 1'b0;

  // Model of the allocator state
  fbpa_pkg::blk_cnt_t pool_size_q   = fbpa_pkg::blk_cnt_t'(fbpa_pkg::MaxBlocks);
  fbpa_pkg::blk_cnt_t next_unused_q = '0;
  fbpa_pkg::blk_cnt_t free_depth_q  = '0;
  fbpa_pkg::blk_idx_t free_stack_q[fbpa_pkg::MaxBlocks];
  bit                 taken_q[fbpa_pkg::MaxBlocks];

  fixed_block_pool_allocator_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (kind),
    .block_index_i  (blk_idx),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .granted_index_o(grant_idx),
    .outcome_o      (outcome)
  );

  always #10 clk = ~clk;

  task automatic predict_request(input fbpa_pkg::kind_e k, input fbpa_pkg::blk_idx_t idx,
                                 output fbpa_pkg::blk_idx_t g,
                                 output fbpa_pkg::outcome_e o);
    fbpa_pkg::blk_cnt_t bound;
    fbpa_pkg::blk_cnt_t pool_max;
    pool_max = fbpa_pkg::blk_cnt_t'(fbpa_pkg::MaxBlocks);
    bound = (pool_size_q > pool_max) ? pool_max : pool_size_q;
    g = '0;
    if (k == fbpa_pkg::KIND_ALLOC) begin
      if (free_depth_q != '0) begin
        free_depth_q = free_depth_q - 7'd1;
        g = free_stack_q[free_depth_q[fbpa_pkg::IdxW-1:0]];
        taken_q[g] = 1'b1;
        o = fbpa_pkg::OUT_GRANTED;
      end else if (next_unused_q < bound) begin
        g = next_unused_q[fbpa_pkg::IdxW-1:0];
        taken_q[g] = 1'b1;
        next_unused_q = next_unused_q + 7'd1;
        o = fbpa_pkg::OUT_GRANTED;
      end else begin
        o = fbpa_pkg::OUT_EXHAUSTED;
      end
    end else begin
      if (!taken_q[idx] || free_depth_q >= pool_max) begin
        o = fbpa_pkg::OUT_IGNORED;
      end else begin
        taken_q[idx] = 1'b0;
        free_stack_q[free_depth_q[fbpa_pkg::IdxW-1:0]] = idx;
        free_depth_q = free_depth_q + 7'd1;
        o = fbpa_pkg::OUT_RELEASED;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic send_request(input fbpa_pkg::kind_e k, input fbpa_pkg::blk_idx_t idx);
    fbpa_pkg::blk_idx_t g;
    fbpa_pkg::outcome_e o;
    @(negedge clk);
    while (!quiet_phase && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    blk_idx  <= idx;
    do @(posedge clk); while (in_stall);
    predict_request(k, idx, g, o);
    pending_results.push_back('{grant: g, outc: o});
    item_count++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_pool_size(input logic [6:0] value);
    wait_for_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    pool_size_q = value;
  endtask

  function automatic fbpa_pkg::blk_idx_t pick_taken_block();
    int unsigned        start;
    fbpa_pkg::blk_idx_t probe;
    start = $urandom_range(fbpa_pkg::MaxBlocks - 1);
    for (int unsigned n = 0; n < fbpa_pkg::MaxBlocks; n++) begin
      probe = fbpa_pkg::blk_idx_t'((start + n) % fbpa_pkg::MaxBlocks);
      if (taken_q[probe]) return probe;
    end
    return fbpa_pkg::blk_idx_t'(start);
  endfunction

  // Fresh counter, stack reuse, double release and release of a never-used block.
  task automatic test_first_grants();
    send_request(fbpa_pkg::KIND_ALLOC, 6'h3F);
    send_request(fbpa_pkg::KIND_ALLOC, 6'h00);
    send_request(fbpa_pkg::KIND_ALLOC, 6'h2A);
    send_request(fbpa_pkg::KIND_ALLOC, 6'h15);
    send_request(fbpa_pkg::KIND_RELEASE, 6'd1);
    send_request(fbpa_pkg::KIND_RELEASE, 6'd1);
    send_request(fbpa_pkg::KIND_RELEASE, 6'd63);
    send_request(fbpa_pkg::KIND_ALLOC, 6'h00);
    send_request(fbpa_pkg::KIND_ALLOC, 6'h00);
  endtask

  // Pool lowered below the counter, pool of zero, and a size above the maximum.
  task automatic test_pool_limits();
    write_pool_size(7'd1);
    send_request(fbpa_pkg::KIND_ALLOC, 6'h00);
    send_request(fbpa_pkg::KIND_RELEASE, 6'd2);
    send_request(fbpa_pkg::KIND_ALLOC, 6'h00);
    send_request(fbpa_pkg::KIND_ALLOC, 6'h00);
    write_pool_size(7'd0);
    send_request(fbpa_pkg::KIND_ALLOC, 6'h00);
    send_request(fbpa_pkg::KIND_RELEASE, 6'd0);
    send_request(fbpa_pkg::KIND_ALLOC, 6'h00);
    send_request(fbpa_pkg::KIND_ALLOC, 6'h00);
    write_pool_size(7'd127);
    send_request(fbpa_pkg::KIND_ALLOC, 6'h00);
    send_request(fbpa_pkg::KIND_ALLOC, 6'h3F);
    write_pool_size(7'd64);
  endtask

  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned alloc_pct;
    logic [6:0]  size;
    phase = 0;
    while (item_count < RandomTarget) begin
      case (phase % 5)
        0:       size = 7'd64;
        1:       size = 7'd127;
        2:       size = 7'($urandom_range(1, 127));
        3:       size = 7'd1;
        default: size = (phase % 10 == 4) ? 7'd0 : 7'($urandom_range(2, 16));
      endcase
      write_pool_size(size);
      case (phase % 3)
        0:       alloc_pct = 90;
        1:       alloc_pct = 15;
        default: alloc_pct = $urandom_range(30, 70);
      endcase
      // One phase runs back to back on both sides
      quiet_phase = (phase == 4);
      for (int unsigned n = 0; n < PhaseItems && item_count < RandomTarget; n++) begin
        if ($urandom_range(99) < alloc_pct) begin
          send_request(fbpa_pkg::KIND_ALLOC,
                       fbpa_pkg::blk_idx_t'($urandom_range(fbpa_pkg::MaxBlocks - 1)));
        end else if ($urandom_range(99) < 80) begin
          send_request(fbpa_pkg::KIND_RELEASE, pick_taken_block());
        end else begin
          send_request(fbpa_pkg::KIND_RELEASE,
                       fbpa_pkg::blk_idx_t'($urandom_range(fbpa_pkg::MaxBlocks - 1)));
        end
        if (n == PhaseItems / 2 && phase % 4 == 1) wait_for_results();
      end
      quiet_phase = 1'b0;
      phase++;
    end
  endtask

  always @(negedge clk) begin
    out_stall <= !quiet_phase && ($urandom_range(99) < 20);
  end

  always @(posedge clk) begin : check_results
    alloc_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, outcome", outcome, -1);
      end else begin
        want = pending_results.pop_front();
        if (grant_idx !== want.grant) report_mismatch("granted index", grant_idx, want.grant);
        if (outcome !== want.outc) report_mismatch("outcome", outcome, want.outc);
      end
    end
  end

  initial begin
    free_stack_q = '{default: '0};
    taken_q      = '{default: 1'b0};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_first_grants();
    test_pool_limits();
    test_random_traffic();
    wait_for_results();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("[fixed_block_pool_allocator_core] OK");
    end else begin
      $display("[fixed_block_pool_allocator_core] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[fixed_block_pool_allocator_core] ERROR");
    $finish;
  end

endmodule
